[rtl/core/plbb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plbb_pkg: shared types and constants for the palette label box block
// Word layouts, queue entry, box entry and back end state codes.
// ----------------------------------------------------------------------------
package plbb_pkg;

  localparam int LABELS     = 64;
  localparam int COORD_BITS = 10;
  localparam int SLOT_W     = 6;
  localparam int RGB_W      = 24;
  localparam int ALPHA_W    = 8;
  localparam int CNT_W      = 7;
  localparam int USED_W     = $clog2(LABELS + 1);
  localparam int LBL_W      = $clog2(LABELS);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL       = 8'hff;
  localparam logic [CNT_W-1:0]   ENTRY_COUNT_RST  = CNT_W'(LABELS);
  localparam logic               REG_ENTRY_COUNT  = 1'b0;
  localparam logic               CMD_LOAD         = 1'b0;
  localparam logic               CMD_PIXEL        = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [SLOT_W-1:0]     slot;
    logic [RGB_W-1:0]      color;
    logic [ALPHA_W-1:0]    alpha;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]     label;
    logic                  seen;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] bottom;
    logic                  bad_color;
    logic                  final_res;
  } box_out_t;

  // classified pixel passed from front to back
  typedef struct packed {
    logic                  hit;
    logic [LBL_W-1:0]      slot;
    logic                  full;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pix_op_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] max_y;
  } box_ent_t;

  localparam int BOX_W = $bits(box_ent_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_UPD,
    S_ERR,
    S_LAST,
    S_DUMP
  } back_state_t;

endpackage
`default_nettype wire

[rtl/core/plbb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plbb_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/plbb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plbb_front: palette store and pixel classifier
// Takes load and pixel words, matches pixel colours against the palette.
// ----------------------------------------------------------------------------
module plbb_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire plbb_pkg::pix_in_t pix,
  output logic                   push,
  output plbb_pkg::pix_op_t      op
);
  import plbb_pkg::*;

  logic [RGB_W-1:0] pal_rgb [LABELS];
  logic [LABELS-1:0] pal_valid;
  logic [LABELS-1:0] match;
  logic              hit;
  logic [LBL_W-1:0]  hit_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (accept && pix.cmd == CMD_LOAD) begin
      pal_valid[pix.slot[LBL_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pix.cmd == CMD_LOAD) begin
      pal_rgb[pix.slot[LBL_W-1:0]] <= pix.color;
    end
  end

  // highest matching slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < LABELS; i++) begin
      match[i] = pal_valid[i] && (pal_rgb[i] == pix.color);
      if (match[i]) begin
        hit      = 1'b1;
        hit_slot = LBL_W'(i);
      end
    end
  end

  assign push    = accept && (pix.cmd == CMD_PIXEL);
  assign op.hit  = hit;
  assign op.slot = hit_slot;
  assign op.full = (pix.alpha == ALPHA_FULL);
  assign op.x    = pix.pos_x;
  assign op.y    = pix.pos_y;
  assign op.last = pix.frame_end;

endmodule
`default_nettype wire

[rtl/core/plbb_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plbb_fifo: short queue of classified pixels
// Decouples the classifier from the box update sequencer.
// ----------------------------------------------------------------------------
module plbb_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire plbb_pkg::pix_op_t wdata,
  input  wire logic              pop,
  output plbb_pkg::pix_op_t      rdata,
  output logic                   empty,
  output logic                   full
);
  import plbb_pkg::*;

  pix_op_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[rtl/core/plbb_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plbb_back: box update and dump sequencer
// Read-modify-write of the box RAM, error reporting and end of frame dump.
// ----------------------------------------------------------------------------
module plbb_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [plbb_pkg::CNT_W-1:0] entry_count,
  input  wire logic                       q_empty,
  input  wire plbb_pkg::pix_op_t          q_data,
  output logic                            pop,
  output logic                            box_valid,
  input  wire logic                       box_stall,
  output plbb_pkg::box_out_t              box
);
  import plbb_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  pix_op_t           cur;
  logic              failed;
  logic [LABELS-1:0] seen;
  logic [LBL_W-1:0]  idx;
  logic [LBL_W-1:0]  idx_next;
  box_out_t          res_next;

  logic [USED_W-1:0] used;
  logic              out_free;
  logic              active;
  logic              err;
  logic              last_idx;
  logic              emit;
  logic              clr;
  logic              set_fail;
  logic              set_seen;
  logic              ram_we;
  logic [LBL_W-1:0]  raddr;
  logic [BOX_W-1:0]  rdata;
  box_ent_t          rd;
  box_ent_t          upd;

  plbb_ram #(
    .WIDTH(BOX_W),
    .DEPTH(LABELS)
  ) u_box_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur.slot),
    .wdata(upd),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd = rdata;

  always_comb begin
    if (entry_count > CNT_W'(LABELS)) begin
      used = USED_W'(LABELS);
    end else begin
      used = USED_W'(entry_count);
    end
  end

  assign out_free = !box_valid || !box_stall;
  assign active   = !failed && cur.full;
  assign err      = active && (!cur.hit || (USED_W'(cur.slot) >= used));
  assign last_idx = ((USED_W'(idx) + 1'b1) == used);

  // a slot not yet seen this frame starts from the pixel itself
  always_comb begin
    if (seen[cur.slot]) begin
      upd.min_x = (cur.x < rd.min_x) ? cur.x : rd.min_x;
      upd.min_y = (cur.y < rd.min_y) ? cur.y : rd.min_y;
      upd.max_x = (cur.x > rd.max_x) ? cur.x : rd.max_x;
      upd.max_y = (cur.y > rd.max_y) ? cur.y : rd.max_y;
    end else begin
      upd.min_x = cur.x;
      upd.min_y = cur.y;
      upd.max_x = cur.x;
      upd.max_y = cur.y;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    raddr      = idx;
    pop        = 1'b0;
    emit       = 1'b0;
    clr        = 1'b0;
    set_fail   = 1'b0;
    set_seen   = 1'b0;
    ram_we     = 1'b0;
    res_next   = box;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        raddr = cur.slot;
        if (err) begin
          set_fail   = 1'b1;
          state_next = S_ERR;
        end else if (active) begin
          state_next = S_UPD;
        end else if (cur.last) begin
          state_next = S_LAST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_UPD: begin
        ram_we     = 1'b1;
        set_seen   = 1'b1;
        state_next = cur.last ? S_LAST : S_IDLE;
      end
      S_ERR: begin
        if (out_free) begin
          emit               = 1'b1;
          res_next.label     = '0;
          res_next.seen      = 1'b0;
          res_next.left      = cur.x;
          res_next.top       = cur.y;
          res_next.right     = '0;
          res_next.bottom    = '0;
          res_next.bad_color = 1'b1;
          res_next.final_res = 1'b1;
          clr                = cur.last;
          state_next         = S_IDLE;
        end
      end
      S_LAST: begin
        raddr    = '0;
        idx_next = '0;
        if (failed || used == '0) begin
          clr        = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit               = 1'b1;
          res_next.label     = SLOT_W'(idx);
          res_next.seen      = seen[idx];
          res_next.left      = seen[idx] ? rd.min_x : '0;
          res_next.top       = seen[idx] ? rd.min_y : '0;
          res_next.right     = seen[idx] ? rd.max_x : '0;
          res_next.bottom    = seen[idx] ? rd.max_y : '0;
          res_next.bad_color = 1'b0;
          res_next.final_res = last_idx;
          if (last_idx) begin
            clr        = 1'b1;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            raddr    = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      failed    <= 1'b0;
      seen      <= '0;
      box_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (emit) begin
        box_valid <= 1'b1;
      end else if (!box_stall) begin
        box_valid <= 1'b0;
      end
      if (clr) begin
        failed <= 1'b0;
        seen   <= '0;
      end else begin
        if (set_fail) begin
          failed <= 1'b1;
        end
        if (set_seen) begin
          seen[cur.slot] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (emit) begin
      box <= res_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/palette_label_bounding_boxes_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_label_bounding_boxes_top: per-label bounding boxes from a pixel stream
// Input words on pix (valid/stall) either load a palette colour or carry a
// pixel. Pixels with full alpha are matched against the palette (highest
// matching slot wins) and widen that slot's box; a miss or a slot at or above
// entry_count gives one error word and the rest of the frame is ignored.
// A pixel marked frame_end triggers a dump of one box word per slot in use,
// the last one flagged final_res, after which the boxes are cleared.
// A pixel is classified at acceptance, queued (four deep) and then taken by
// the box sequencer: pop, box RAM read, then box RAM write or error word (the
// read is the last step when skipped or ignored). The next pixel is popped
// only once the last is done. A dump reads the slots in use one after another
// through the single box RAM read port. pix_stall rises only when the queue
// is full. Results sit in an output register; a box_stall holds it and the
// sequencer waits whenever it has a word to send, so the queue can fill.
// Reset (synchronous, rst high) clears the palette, the boxes and the queue
// and sets entry_count to 64. entry_count is written over the APB port at
// byte address 0 and is read back there; pready is always high.
// ----------------------------------------------------------------------------
module palette_label_bounding_boxes_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pix_valid,
  output logic                              pix_stall,
  input  wire plbb_pkg::pix_in_t            pix,
  output logic                              box_valid,
  input  wire logic                         box_stall,
  output plbb_pkg::box_out_t                box,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [plbb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [plbb_pkg::PDATA_W-1:0] pwdata,
  output logic      [plbb_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import plbb_pkg::*;

  logic [CNT_W-1:0] entry_count;
  logic             accept;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  pix_op_t          op;
  pix_op_t          q_data;

  assign pready    = 1'b1;
  assign pix_stall = q_full;
  assign accept    = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_COUNT) begin
      entry_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = PDATA_W'(entry_count);
    end else begin
      prdata = '0;
    end
  end

  plbb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .pix   (pix),
    .push  (push),
    .op    (op)
  );

  plbb_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(op),
    .pop  (pop),
    .rdata(q_data),
    .empty(q_empty),
    .full (q_full)
  );

  plbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .entry_count(entry_count),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .pop        (pop),
    .box_valid  (box_valid),
    .box_stall  (box_stall),
    .box        (box)
  );

endmodule
`default_nettype wire

[tb/sv/palette_label_bounding_boxes_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_label_bounding_boxes_top_test: self-checking bench for the label box block
// A short directed table covers reset, the palette, skipped and ignored pixels,
// errors and dumps. Random frames then run under several entry_count values.
// Each word is predicted by a local box tracker (typed table rows give it
// directly) and compared field by field with the block's output, under random
// gaps on both sides and one long receiver hold-off that fills the input queue.
// ----------------------------------------------------------------------------
module palette_label_bounding_boxes_top_test;
  import plbb_pkg::*;

  localparam int RAND_ITEMS  = 410;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYC    = 300;
  localparam int LIMIT       = 2000000;
  localparam int PRESS_PHASE = 2;
  localparam logic [PADDR_W-1:0] COUNT_ADDR = PADDR_W'(4 * REG_ENTRY_COUNT);
  localparam box_out_t NO_BOX = '0;

  typedef enum {ROW_LOAD, ROW_PIX, ROW_CFG} row_kind_t;

  // for a register row the value travels in x
  typedef struct {
    row_kind_t             kind;
    logic [SLOT_W-1:0]     slot;
    logic [RGB_W-1:0]      color;
    logic [ALPHA_W-1:0]    alpha;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
    bit                    typed;
    box_out_t              want;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                pix_valid = 1'b0;
  logic                pix_stall;
  pix_in_t             pix       = '0;
  logic                box_valid;
  logic                box_stall = 1'b0;
  box_out_t            box;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // local copy of the block state
  logic [RGB_W-1:0]      pal_rgb [LABELS];
  bit                    pal_ok  [LABELS];
  logic [COORD_BITS-1:0] lo_x    [LABELS];
  logic [COORD_BITS-1:0] lo_y    [LABELS];
  logic [COORD_BITS-1:0] hi_x    [LABELS];
  logic [COORD_BITS-1:0] hi_y    [LABELS];
  bit                    hit_any [LABELS];
  bit                    frame_bad;
  int unsigned           ent_cnt = ENTRY_COUNT_RST;

  box_out_t    box_exp_q [$];
  box_out_t    want_box;
  int unsigned mismatches = 0;
  int unsigned n_items    = 0;
  int unsigned cyc_count  = 0;
  bit          tx_gaps    = 1'b1;
  bit          rx_gaps    = 1'b1;
  bit          hold_req   = 1'b0;
  int          rx_left    = 0;
  int          rx_hold    = 0;

  int unsigned ec_plan [7] = '{64, 1, 3, 63, 2, 64, 17};

  dir_row_t dir_tab [22] = '{
    // nothing loaded yet: a miss right after reset
    '{ROW_PIX,   0, 24'h000000, 8'hff,    0,    0, 0, 1, '{0, 0,    0,    0, 0, 0, 1, 1}},
    '{ROW_PIX,   0, 24'h000000, 8'hff, 1023, 1023, 1, 0, NO_BOX},
    '{ROW_LOAD,  0, 24'hffffff, 8'h00,    0,    0, 0, 0, NO_BOX},
    '{ROW_LOAD, 63, 24'h000000, 8'h00,    0,    0, 0, 0, NO_BOX},
    '{ROW_LOAD,  5, 24'h123456, 8'h00,    0,    0, 0, 0, NO_BOX},
    // same colour twice, frame_end on a load does nothing
    '{ROW_LOAD,  9, 24'h123456, 8'hff, 1023, 1023, 1, 0, NO_BOX},
    '{ROW_LOAD,  1, 24'habcdef, 8'h00,    0,    0, 0, 0, NO_BOX},
    '{ROW_PIX,   0, 24'hffffff, 8'hff, 1023,    0, 0, 0, NO_BOX},
    '{ROW_PIX,   0, 24'h000000, 8'hff,    0, 1023, 0, 0, NO_BOX},
    '{ROW_PIX,   0, 24'h123456, 8'hfe,    0,    0, 0, 0, NO_BOX},
    '{ROW_PIX,   0, 24'h123456, 8'hff,    5,    7, 0, 0, NO_BOX},
    '{ROW_PIX,   0, 24'h123456, 8'hff,  700,  300, 1, 0, NO_BOX},
    // skipped pixel still closes the frame: all boxes empty
    '{ROW_PIX,   0, 24'h000000, 8'h00,  512,  512, 1, 0, NO_BOX},
    '{ROW_PIX,   0, 24'h00ff00, 8'hff, 1023, 1023, 1, 1, '{0, 0, 1023, 1023, 0, 0, 1, 1}},
    '{ROW_CFG,   0, 24'h000000, 8'h00,    1,    0, 0, 0, NO_BOX},
    // slot 63 is out of range with one label
    '{ROW_PIX,   0, 24'h000000, 8'hff,    3,    4, 0, 1, '{0, 0,    3,    4, 0, 0, 1, 1}},
    '{ROW_PIX,   0, 24'hffffff, 8'hff,    9,    9, 1, 0, NO_BOX},
    '{ROW_PIX,   0, 24'hffffff, 8'hff,   10,   20, 0, 0, NO_BOX},
    '{ROW_PIX,   0, 24'hffffff, 8'hff,   30,    5, 1, 1, '{0, 1,   10,    5, 30, 20, 0, 1}},
    '{ROW_LOAD,  5, 24'hffffff, 8'h00,    0,    0, 0, 0, NO_BOX},
    '{ROW_CFG,   0, 24'h000000, 8'h00,   64,    0, 0, 0, NO_BOX},
    '{ROW_PIX,   0, 24'hffffff, 8'hff,    1,    1, 1, 0, NO_BOX}
  };

  palette_label_bounding_boxes_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box       (box),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void clear_boxes();
    for (int i = 0; i < LABELS; i++) begin
      lo_x[i]    = '1;
      lo_y[i]    = '1;
      hi_x[i]    = '0;
      hi_y[i]    = '0;
      hit_any[i] = 1'b0;
    end
    frame_bad = 1'b0;
  endfunction

  // returns 1 when the word is not simply ignored by the block
  function automatic bit track_boxes(input pix_in_t w, ref box_out_t out_q[$]);
    int       hit;
    int       used;
    bit       counts;
    box_out_t b;
    used   = (ent_cnt > LABELS) ? LABELS : ent_cnt;
    counts = 1'b0;
    if (w.cmd == CMD_LOAD) begin
      pal_rgb[w.slot] = w.color;
      pal_ok[w.slot]  = 1'b1;
      return 1'b1;
    end
    if (!frame_bad && w.alpha == ALPHA_FULL) begin
      counts = 1'b1;
      hit    = -1;
      // highest matching slot wins
      for (int i = 0; i < LABELS; i++)
        if (pal_ok[i] && pal_rgb[i] == w.color) hit = i;
      if (hit < 0 || hit >= used) begin
        frame_bad   = 1'b1;
        b           = '0;
        b.left      = w.pos_x;
        b.top       = w.pos_y;
        b.bad_color = 1'b1;
        b.final_res = 1'b1;
        out_q.push_back(b);
      end else begin
        if (w.pos_x < lo_x[hit]) lo_x[hit] = w.pos_x;
        if (w.pos_y < lo_y[hit]) lo_y[hit] = w.pos_y;
        if (w.pos_x > hi_x[hit]) hi_x[hit] = w.pos_x;
        if (w.pos_y > hi_y[hit]) hi_y[hit] = w.pos_y;
        hit_any[hit] = 1'b1;
      end
    end
    if (w.frame_end) begin
      counts = 1'b1;
      if (!frame_bad) begin
        for (int i = 0; i < used; i++) begin
          b           = '0;
          b.label     = SLOT_W'(i);
          b.final_res = (i == used - 1);
          if (hit_any[i]) begin
            b.seen   = 1'b1;
            b.left   = lo_x[i];
            b.top    = lo_y[i];
            b.right  = hi_x[i];
            b.bottom = hi_y[i];
          end
          out_q.push_back(b);
        end
      end
      clear_boxes();
    end
    return counts;
  endfunction

  function automatic void cmp_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && box_valid && !box_stall) begin
      if (box_exp_q.size() == 0) begin
        $error("result word with none expected: label %0d", box.label);
        mismatches++;
      end else begin
        want_box = box_exp_q.pop_front();
        cmp_field("label",     want_box.label,     box.label);
        cmp_field("seen",      want_box.seen,      box.seen);
        cmp_field("left",      want_box.left,      box.left);
        cmp_field("top",       want_box.top,       box.top);
        cmp_field("right",     want_box.right,     box.right);
        cmp_field("bottom",    want_box.bottom,    box.bottom);
        cmp_field("bad_color", want_box.bad_color, box.bad_color);
        cmp_field("final_res", want_box.final_res, box.final_res);
      end
    end
  end

  // result side: per-word random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      box_stall <= 1'b0;
      rx_left = 0;
    end else if (hold_req || rx_hold > 0) begin
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold  = HOLD_CYC;
      end
      rx_hold--;
      box_stall <= 1'b1;
    end else begin
      if (box_valid && !box_stall) rx_left = rx_gaps ? $urandom_range(0, 12) : 0;
      else if (rx_left > 0) rx_left--;
      box_stall <= (rx_left != 0);
    end
  end

  task automatic put_word(input pix_in_t w, input bit typed, input box_out_t typed_res);
    box_out_t pred_q [$];
    int       gap;
    gap = tx_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix       <= w;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    if (track_boxes(w, pred_q)) n_items++;
    if (typed) box_exp_q.push_back(typed_res);
    else foreach (pred_q[i]) box_exp_q.push_back(pred_q[i]);
  endtask

  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (box_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves psel high so that transfers can follow back to back
  task automatic apb_xfer(input bit wr, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= COUNT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic access_count(input bit wr, input int unsigned val);
    logic [PDATA_W-1:0] rd;
    if (wr) apb_xfer(1'b1, PDATA_W'(val), rd);
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) ent_cnt = val;
    if (rd[CNT_W-1:0] !== CNT_W'(ent_cnt)) begin
      $error("entry_count: expected %0d, got %0d", ent_cnt, rd[CNT_W-1:0]);
      mismatches++;
    end
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return COORD_BITS'($urandom);
  endfunction

  function automatic pix_in_t rand_load();
    pix_in_t w;
    w.cmd       = CMD_LOAD;
    w.slot      = SLOT_W'($urandom);
    w.color     = $urandom_range(0, 1) ? RGB_W'($urandom)
                                       : pal_rgb[$urandom_range(0, LABELS - 1)];
    w.alpha     = ALPHA_W'($urandom);
    w.pos_x     = COORD_BITS'($urandom);
    w.pos_y     = COORD_BITS'($urandom);
    w.frame_end = 1'($urandom);
    return w;
  endfunction

  function automatic pix_in_t rand_pixel(input int used, input bit last);
    pix_in_t w;
    int      pick;
    w.cmd       = CMD_PIXEL;
    w.slot      = SLOT_W'($urandom);
    w.alpha     = ALPHA_FULL;
    w.pos_x     = rand_coord();
    w.pos_y     = rand_coord();
    w.frame_end = last;
    pick        = $urandom_range(0, 99);
    if (pick < 4) begin
      w.color = RGB_W'($urandom);
    end else if (pick < 10) begin
      w.alpha = ALPHA_W'($urandom_range(0, 254));
      w.color = pal_rgb[$urandom_range(0, LABELS - 1)];
    end else if (pick < 16) begin
      // any slot, so out-of-range labels turn up
      w.color = pal_rgb[$urandom_range(0, LABELS - 1)];
    end else begin
      w.color = pal_rgb[$urandom_range(0, used - 1)];
    end
    return w;
  endfunction

  task automatic run_frame(input int n_px);
    int used;
    used = (ent_cnt > LABELS) ? LABELS : ent_cnt;
    repeat ($urandom_range(0, 2)) put_word(rand_load(), 1'b0, NO_BOX);
    for (int k = 0; k < n_px; k++)
      put_word(rand_pixel(used, k == n_px - 1), 1'b0, NO_BOX);
  endtask

  initial begin
    pix_in_t  w;
    dir_row_t r;
    int       phase;
    for (int i = 0; i < LABELS; i++) begin
      pal_ok[i]  = 1'b0;
      pal_rgb[i] = '0;
    end
    clear_boxes();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    access_count(1'b0, 0);

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.kind == ROW_CFG) begin
        wait_idle();
        access_count(1'b1, r.x);
      end else begin
        w.cmd       = (r.kind == ROW_LOAD) ? CMD_LOAD : CMD_PIXEL;
        w.slot      = r.slot;
        w.color     = r.color;
        w.alpha     = r.alpha;
        w.pos_x     = r.x;
        w.pos_y     = r.y;
        w.frame_end = r.last;
        put_word(w, r.typed, r.want);
      end
    end

    // fill the whole palette so most pixels find a label
    n_items = 0;
    for (int s = 0; s < LABELS; s++) begin
      w      = rand_load();
      w.slot = SLOT_W'(s);
      put_word(w, 1'b0, NO_BOX);
    end

    phase = 0;
    while (n_items < RAND_ITEMS) begin
      wait_idle();
      access_count(1'b1, (phase < $size(ec_plan)) ? ec_plan[phase]
                                                  : $urandom_range(1, LABELS));
      if (phase == PRESS_PHASE) begin
        // short dumps while the result side is held off: the queue fills up
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (10) run_frame($urandom_range(1, 2));
      end else begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_gaps = ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(2, 5)) begin
          run_frame($urandom_range(1, 12));
          if ($urandom_range(0, 9) == 0) wait_idle();
        end
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/plbb_pkg.sv
rtl/core/plbb_ram.sv
rtl/core/plbb_front.sv
rtl/core/plbb_fifo.sv
rtl/core/plbb_back.sv
rtl/core/palette_label_bounding_boxes_top.sv
tb/sv/palette_label_bounding_boxes_top_test.sv
